// ----- rtl/jtg_pkg.sv -----
// Package for the joint trajectory guard: widths, codes, structs and the
// constant residue tables used to wrap the roll joint step.
// No dependencies; every other file of the block imports it.
package jtg_pkg;

  // Widths fixed by the point and verdict formats.
  localparam int NUM_JOINTS   = 6;
  localparam int POS_W        = 32;
  localparam int DELTA_W      = POS_W + 1;
  localparam int MAG_W        = POS_W;
  localparam int POINT_W      = 16;
  localparam int COUNT_W      = 4;
  localparam int MASK_W       = NUM_JOINTS;
  localparam int JOINT_W      = 3;
  localparam int LIMIT_W      = 31;
  localparam int STILL_W      = 10;
  localparam int FLIPS_W      = 3;
  localparam int RUN_W        = 4;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 31;

  // Joint groups.
  localparam int BASE_JOINTS  = 3;
  localparam int ROLL_JOINT   = 5;
  localparam int WRIST_FIRST  = 3;
  localparam int WRIST_COUNT  = 3;

  // Roll wrap: 2*pi in Q11.20 and the first residue that folds to the negative side.
  localparam int unsigned TWO_PI_Q20 = 6588397;
  localparam int unsigned HALF_UP    = (TWO_PI_Q20 + 1) / 2;
  localparam int ROLL_RES_W = 23;
  localparam int ROLL_LO_W  = 23;
  localparam int ROLL_MID_W = 6;
  localparam int ROLL_HI_W  = DELTA_W - ROLL_LO_W - ROLL_MID_W;
  localparam int ROLL_SUM_W = 25;
  localparam int ROLL_SEGS  = 4;

  localparam logic [POINT_W-1:0] POINT_MAX = {POINT_W{1'b1}};
  localparam logic [RUN_W-1:0]   RUN_MAX   = {RUN_W{1'b1}};

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef enum logic [2:0] {
    VERDICT_ACCEPT         = 3'd0,
    VERDICT_NO_JOINTS      = 3'd1,
    VERDICT_COUNT_MISMATCH = 3'd2,
    VERDICT_NON_FINITE     = 3'd3,
    VERDICT_JUMP           = 3'd4,
    VERDICT_FLIPS          = 3'd5
  } verdict_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_JOINT_COUNT  = 3'd0,
    CFG_LIMIT_BASE   = 3'd1,
    CFG_LIMIT_WRIST  = 3'd2,
    CFG_LIMIT_ROLL   = 3'd3,
    CFG_STILL        = 3'd4,
    CFG_MAX_FLIPS    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [JOINT_W-1:0] joint_count;
    logic [LIMIT_W-1:0] limit_base;
    logic [LIMIT_W-1:0] limit_wrist;
    logic [LIMIT_W-1:0] limit_roll;
    logic [STILL_W-1:0] still;
    logic [FLIPS_W-1:0] max_flips;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    joint_count: JOINT_W'(6),
    limit_base:  LIMIT_W'(524288),
    limit_wrist: LIMIT_W'(524288),
    limit_roll:  LIMIT_W'(524288),
    still:       STILL_W'(2),
    max_flips:   FLIPS_W'(5)
  };

  // Per-point bookkeeping that travels alongside the deltas.
  typedef struct packed {
    logic               have_prev;
    logic [POINT_W-1:0] idx;
    logic [COUNT_W-1:0] count;
    logic [MASK_W-1:0]  nf;
    logic               last;
  } point_info_t;

  typedef logic signed [DELTA_W-1:0] delta_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    dir_t             dir;
  } motion_t;

  typedef struct packed {
    verdict_t           verdict;
    logic [JOINT_W-1:0] joint;
    logic [POINT_W-1:0] point;
  } result_t;

  // Residues of the upper delta chunks modulo 2*pi. The top chunk holds the
  // sign bit, so its weight is negative.
  typedef logic [ROLL_RES_W-1:0] roll_res_t;
  typedef roll_res_t roll_hi_tab_t  [2**ROLL_HI_W];
  typedef roll_res_t roll_mid_tab_t [2**ROLL_MID_W];

  // Residue of a constant modulo 2*pi in [0, 2*pi), by shift and subtract.
  function automatic longint roll_residue(longint v);
    longint mag;
    longint step;
    mag = (v < 0) ? -v : v;
    for (int s = 31; s >= 0; s--) begin
      step = longint'(TWO_PI_Q20) <<< s;
      if (mag >= step) mag = mag - step;
    end
    if (v < 0 && mag != 0) mag = longint'(TWO_PI_Q20) - mag;
    return mag;
  endfunction

  function automatic roll_hi_tab_t make_roll_hi_tab();
    roll_hi_tab_t tab;
    longint       v;
    for (int i = 0; i < 2**ROLL_HI_W; i++) begin
      v = longint'(i);
      if (i >= 2**(ROLL_HI_W - 1)) v = v - longint'(2**ROLL_HI_W);
      v = v * (longint'(1) <<< (ROLL_LO_W + ROLL_MID_W));
      tab[i] = roll_res_t'(roll_residue(v));
    end
    return tab;
  endfunction

  function automatic roll_mid_tab_t make_roll_mid_tab();
    roll_mid_tab_t tab;
    longint        v;
    for (int i = 0; i < 2**ROLL_MID_W; i++) begin
      v = longint'(i) * (longint'(1) <<< ROLL_LO_W);
      tab[i] = roll_res_t'(roll_residue(v));
    end
    return tab;
  endfunction

  localparam roll_hi_tab_t  ROLL_HI_TAB  = make_roll_hi_tab();
  localparam roll_mid_tab_t ROLL_MID_TAB = make_roll_mid_tab();

endpackage

// ----- rtl/jtg_if.sv -----
// Channel interfaces of the joint trajectory guard: point input and verdict output.
// Depends on jtg_pkg for the field widths.
interface jtg_point_if;
  import jtg_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  pos_0;
  logic signed [POS_W-1:0]  pos_1;
  logic signed [POS_W-1:0]  pos_2;
  logic signed [POS_W-1:0]  pos_3;
  logic signed [POS_W-1:0]  pos_4;
  logic signed [POS_W-1:0]  pos_5;
  logic [COUNT_W-1:0]       position_count;
  logic [MASK_W-1:0]        non_finite_mask;
  logic                     last_point;

  modport source (
    output valid, pos_0, pos_1, pos_2, pos_3, pos_4, pos_5,
    output position_count, non_finite_mask, last_point,
    input  ready
  );

  modport sink (
    input  valid, pos_0, pos_1, pos_2, pos_3, pos_4, pos_5,
    input  position_count, non_finite_mask, last_point,
    output ready
  );
endinterface

interface jtg_verdict_if;
  import jtg_pkg::*;

  logic               valid;
  logic               ready;
  logic [2:0]         verdict;
  logic [JOINT_W-1:0] fail_joint;
  logic [POINT_W-1:0] fail_point;

  modport source (output valid, verdict, fail_joint, fail_point, input ready);
  modport sink (input valid, verdict, fail_joint, fail_point, output ready);
endinterface

// ----- rtl/jtg_front.sv -----
// Front stage: takes point beats, keeps the previous point and the point
// index, and registers the per-joint deltas. Depends on jtg_pkg.
module jtg_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [jtg_pkg::POS_W-1:0] pos_i [jtg_pkg::NUM_JOINTS],
  input  logic [jtg_pkg::COUNT_W-1:0]      count_i,
  input  logic [jtg_pkg::MASK_W-1:0]       nf_i,
  input  logic                             last_i,
  output logic                             d_valid_o,
  input  logic                             d_ready_i,
  output jtg_pkg::delta_t                  delta_o [jtg_pkg::NUM_JOINTS],
  output jtg_pkg::point_info_t             info_o
);
  import jtg_pkg::*;

  logic                    accept;
  logic                    d_valid_r;
  logic                    have_prev_r;
  logic [POINT_W-1:0]      point_idx_r;
  logic [POINT_W-1:0]      point_idx_nxt;
  logic signed [POS_W-1:0] prev_r [NUM_JOINTS];
  delta_t                  delta_r [NUM_JOINTS];
  point_info_t             info_r;

  assign in_ready = !d_valid_r || d_ready_i;
  assign accept   = in_valid && in_ready;

  // Index of the next point: saturates, and restarts after the last point.
  always_comb begin
    if (last_i) begin
      point_idx_nxt = '0;
    end else if (point_idx_r == POINT_MAX) begin
      point_idx_nxt = point_idx_r;
    end else begin
      point_idx_nxt = point_idx_r + 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r   <= 1'b0;
      have_prev_r <= 1'b0;
      point_idx_r <= '0;
    end else begin
      if (in_ready) d_valid_r <= in_valid;
      if (accept) begin
        have_prev_r <= !last_i;
        point_idx_r <= point_idx_nxt;
      end
    end
  end

  // Previous point and the deltas against it.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int j = 0; j < NUM_JOINTS; j++) begin
        prev_r[j]  <= pos_i[j];
        delta_r[j] <= {pos_i[j][POS_W-1], pos_i[j]} - {prev_r[j][POS_W-1], prev_r[j]};
      end
      info_r <= '{have_prev: have_prev_r, idx: point_idx_r, count: count_i,
                  nf: nf_i, last: last_i};
    end
  end

  assign d_valid_o = d_valid_r;
  assign delta_o   = delta_r;
  assign info_o    = info_r;

endmodule

// ----- rtl/jtg_measure.sv -----
// Measure stages: step magnitude and direction per joint, with the roll joint
// step wrapped into (-pi, pi] over two stages. Depends on jtg_pkg.
module jtg_measure (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 d_valid_i,
  output logic                 d_ready_o,
  input  jtg_pkg::delta_t      delta_i [jtg_pkg::NUM_JOINTS],
  input  jtg_pkg::point_info_t info_i,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  output jtg_pkg::motion_t     mot_o [jtg_pkg::NUM_JOINTS],
  output jtg_pkg::point_info_t info_o
);
  import jtg_pkg::*;

  logic                  a_valid_r;
  logic                  a_ready;
  point_info_t           a_info_r;
  motion_t               a_mot_r [ROLL_JOINT];
  logic [ROLL_SUM_W-1:0] a_roll_sum_r;
  logic [ROLL_SUM_W-1:0] roll_sum_nxt;

  logic                  b_valid_r;
  logic                  b_ready;
  point_info_t           b_info_r;
  motion_t               b_mot_r [NUM_JOINTS];
  motion_t               roll_mot;

  function automatic motion_t to_motion(input delta_t d);
    motion_t            m;
    logic [DELTA_W-1:0] neg;
    neg   = -d;
    m.mag = d[DELTA_W-1] ? neg[MAG_W-1:0] : d[MAG_W-1:0];
    m.dir = d[DELTA_W-1] ? DIR_DOWN : ((d == '0) ? DIR_NONE : DIR_UP);
    return m;
  endfunction

  assign b_ready   = !b_valid_r || m_ready_i;
  assign a_ready   = !a_valid_r || b_ready;
  assign d_ready_o = a_ready;

  // Roll delta residue: table residues of the upper chunks plus the low bits.
  assign roll_sum_nxt =
      ROLL_SUM_W'(ROLL_HI_TAB[delta_i[ROLL_JOINT][DELTA_W-1 -: ROLL_HI_W]])
    + ROLL_SUM_W'(ROLL_MID_TAB[delta_i[ROLL_JOINT][ROLL_LO_W+ROLL_MID_W-1 -: ROLL_MID_W]])
    + ROLL_SUM_W'(delta_i[ROLL_JOINT][ROLL_LO_W-1:0]);

  // The residue sum lies below four periods. Each period splits into an upward
  // half and a downward half; the magnitude is measured from its nearer end.
  always_comb begin
    roll_mot = '{mag: '0, dir: DIR_NONE};
    for (int k = 0; k < ROLL_SEGS; k++) begin
      if (a_roll_sum_r >= ROLL_SUM_W'(k * TWO_PI_Q20)) begin
        if (a_roll_sum_r >= ROLL_SUM_W'(k * TWO_PI_Q20 + HALF_UP)) begin
          roll_mot.mag = MAG_W'(ROLL_SUM_W'((k + 1) * TWO_PI_Q20) - a_roll_sum_r);
          roll_mot.dir = DIR_DOWN;
        end else begin
          roll_mot.mag = MAG_W'(a_roll_sum_r - ROLL_SUM_W'(k * TWO_PI_Q20));
          roll_mot.dir = (a_roll_sum_r == ROLL_SUM_W'(k * TWO_PI_Q20)) ? DIR_NONE : DIR_UP;
        end
      end
    end
  end

  // Stage valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_ready) a_valid_r <= d_valid_i;
      if (b_ready) b_valid_r <= a_valid_r;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (a_ready && d_valid_i) begin
      for (int j = 0; j < ROLL_JOINT; j++) begin
        a_mot_r[j] <= to_motion(delta_i[j]);
      end
      a_roll_sum_r <= roll_sum_nxt;
      a_info_r     <= info_i;
    end
    if (b_ready && a_valid_r) begin
      for (int j = 0; j < ROLL_JOINT; j++) begin
        b_mot_r[j] <= a_mot_r[j];
      end
      b_mot_r[ROLL_JOINT] <= roll_mot;
      b_info_r            <= a_info_r;
    end
  end

  assign m_valid_o = b_valid_r;
  assign mot_o     = b_mot_r;
  assign info_o    = b_info_r;

endmodule

// ----- rtl/jtg_judge.sv -----
// Judge stage: keeps the trajectory findings (malformed point, jump, wrist
// reversal runs) and registers the verdict on the last point. Depends on jtg_pkg.
module jtg_judge (
  input  logic                 clk,
  input  logic                 rst_n,
  input  jtg_pkg::cfg_t        cfg_i,
  input  logic                 m_valid_i,
  output logic                 m_ready_o,
  input  jtg_pkg::motion_t     mot_i [jtg_pkg::NUM_JOINTS],
  input  jtg_pkg::point_info_t info_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output jtg_pkg::result_t     result_o
);
  import jtg_pkg::*;

  typedef struct packed {
    verdict_t                                   mal_code;
    logic [JOINT_W-1:0]                         mal_joint;
    logic [POINT_W-1:0]                         mal_point;
    logic                                       jump_found;
    logic [JOINT_W-1:0]                         jump_joint;
    logic [POINT_W-1:0]                         jump_point;
    dir_t [WRIST_COUNT-1:0]                     last_dir;
    logic [WRIST_COUNT-1:0][RUN_W-1:0]          flip_run;
    logic [WRIST_COUNT-1:0]                     flip_failed;
    logic [WRIST_COUNT-1:0][POINT_W-1:0]        flip_point;
  } track_t;

  track_t             st_r;
  track_t             st_nxt;
  logic               fire;
  logic [JOINT_W-1:0] eff;
  logic               active [NUM_JOINTS];
  logic [LIMIT_W-1:0] limit_sel [NUM_JOINTS];
  logic               over [NUM_JOINTS];
  logic [RUN_W-1:0]   run_inc [WRIST_COUNT];
  result_t            res;
  logic               out_valid_r;
  result_t            result_r;

  // A last point may only finish once the verdict register is free.
  assign m_ready_o = !info_i.last || !out_valid_r || out_ready_i;
  assign fire      = m_valid_i && m_ready_o;

  // Joints in use and the step limit of each.
  always_comb begin
    eff = (cfg_i.joint_count > JOINT_W'(NUM_JOINTS)) ? JOINT_W'(NUM_JOINTS)
                                                     : cfg_i.joint_count;
    for (int j = 0; j < NUM_JOINTS; j++) begin
      active[j] = JOINT_W'(j) < eff;
      if (j < BASE_JOINTS) begin
        limit_sel[j] = cfg_i.limit_base;
      end else if (j < ROLL_JOINT) begin
        limit_sel[j] = cfg_i.limit_wrist;
      end else begin
        limit_sel[j] = cfg_i.limit_roll;
      end
      over[j] = info_i.have_prev && active[j] && (mot_i[j].mag > MAG_W'(limit_sel[j]));
    end
    for (int w = 0; w < WRIST_COUNT; w++) begin
      run_inc[w] = (st_r.flip_run[w] == RUN_MAX) ? st_r.flip_run[w]
                                                 : st_r.flip_run[w] + 1'b1;
    end
  end

  // Findings after this point.
  always_comb begin
    st_nxt = st_r;

    // First malformed point: count mismatch, else lowest non-finite joint.
    if (st_r.mal_code == VERDICT_ACCEPT) begin
      if (info_i.count != COUNT_W'(cfg_i.joint_count)) begin
        st_nxt.mal_code  = VERDICT_COUNT_MISMATCH;
        st_nxt.mal_joint = '0;
        st_nxt.mal_point = info_i.idx;
      end else begin
        for (int j = NUM_JOINTS - 1; j >= 0; j--) begin
          if (active[j] && info_i.nf[j]) begin
            st_nxt.mal_code  = VERDICT_NON_FINITE;
            st_nxt.mal_joint = JOINT_W'(j);
            st_nxt.mal_point = info_i.idx;
          end
        end
      end
    end

    // First over-limit step, lowest joint on that point.
    if (!st_r.jump_found) begin
      for (int j = NUM_JOINTS - 1; j >= 0; j--) begin
        if (over[j]) begin
          st_nxt.jump_found = 1'b1;
          st_nxt.jump_joint = JOINT_W'(j);
          st_nxt.jump_point = info_i.idx;
        end
      end
    end

    // Wrist reversal runs; steps below the still threshold are skipped.
    for (int w = 0; w < WRIST_COUNT; w++) begin
      if (info_i.have_prev && active[WRIST_FIRST + w] && !st_r.flip_failed[w] &&
          !(mot_i[WRIST_FIRST + w].mag < MAG_W'(cfg_i.still))) begin
        if (st_r.last_dir[w] != DIR_NONE) begin
          if (mot_i[WRIST_FIRST + w].dir != DIR_NONE &&
              mot_i[WRIST_FIRST + w].dir != st_r.last_dir[w]) begin
            st_nxt.flip_run[w] = run_inc[w];
            if (run_inc[w] > RUN_W'(cfg_i.max_flips)) begin
              st_nxt.flip_failed[w] = 1'b1;
              st_nxt.flip_point[w]  = info_i.idx;
            end
          end else begin
            st_nxt.flip_run[w] = '0;
          end
        end
        st_nxt.last_dir[w] = mot_i[WRIST_FIRST + w].dir;
      end
    end
  end

  // Verdict by precedence over the updated findings.
  always_comb begin
    res = '{verdict: VERDICT_ACCEPT, joint: '0, point: '0};
    if (cfg_i.joint_count == '0) begin
      res.verdict = VERDICT_NO_JOINTS;
    end else if (st_nxt.mal_code != VERDICT_ACCEPT) begin
      res = '{verdict: st_nxt.mal_code, joint: st_nxt.mal_joint, point: st_nxt.mal_point};
    end else if (st_nxt.jump_found) begin
      res = '{verdict: VERDICT_JUMP, joint: st_nxt.jump_joint, point: st_nxt.jump_point};
    end else begin
      for (int w = WRIST_COUNT - 1; w >= 0; w--) begin
        if (st_nxt.flip_failed[w]) begin
          res = '{verdict: VERDICT_FLIPS, joint: JOINT_W'(WRIST_FIRST + w),
                  point: st_nxt.flip_point[w]};
        end
      end
    end
  end

  // Trajectory findings, cleared after the last point.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (fire) begin
      if (info_i.last) begin
        st_r <= '0;
      end else begin
        st_r <= st_nxt;
      end
    end
  end

  // Verdict register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && info_i.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && info_i.last) result_r <= res;
  end

  assign out_valid_o = out_valid_r;
  assign result_o    = result_r;

endmodule

// ----- rtl/joint_trajectory_guard_top.sv -----
// Top level of the joint trajectory guard: configuration registers and the
// front, measure and judge stages. Depends on jtg_pkg, jtg_if and the stages.
//
//   channel       direction  beat holds                                   handshake
//   in_point      in         pos_0..pos_5, position_count, mask, last     valid/ready
//   out_verdict   out        verdict, fail_joint, fail_point              valid/ready
//   cfg_*         in         cfg_index, cfg_wdata                         cfg_we
//
// One point per cycle. A last point runs through front and measure to the verdict register.
// The pipeline holds only when a last point reaches the judge stage while the
// previous verdict still sits unread in the output register.
// Reset is synchronous: it empties the pipeline, clears the trajectory findings
// and loads the register defaults.
module joint_trajectory_guard_top (
  input  logic                               clk,
  input  logic                               rst_n,
  jtg_point_if.sink                          in_point,
  jtg_verdict_if.source                      out_verdict,
  input  logic                               cfg_we,
  input  logic [jtg_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [jtg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import jtg_pkg::*;

  cfg_t                    cfg_r;
  logic signed [POS_W-1:0] pos [NUM_JOINTS];
  logic                    d_valid;
  logic                    d_ready;
  delta_t                  delta [NUM_JOINTS];
  point_info_t             d_info;
  logic                    m_valid;
  logic                    m_ready;
  motion_t                 mot [NUM_JOINTS];
  point_info_t             m_info;
  result_t                 result;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_JOINT_COUNT: cfg_r.joint_count <= cfg_wdata[JOINT_W-1:0];
        CFG_LIMIT_BASE:  cfg_r.limit_base  <= cfg_wdata[LIMIT_W-1:0];
        CFG_LIMIT_WRIST: cfg_r.limit_wrist <= cfg_wdata[LIMIT_W-1:0];
        CFG_LIMIT_ROLL:  cfg_r.limit_roll  <= cfg_wdata[LIMIT_W-1:0];
        CFG_STILL:       cfg_r.still       <= cfg_wdata[STILL_W-1:0];
        CFG_MAX_FLIPS:   cfg_r.max_flips   <= cfg_wdata[FLIPS_W-1:0];
        default: ;
      endcase
    end
  end

  assign pos[0] = in_point.pos_0;
  assign pos[1] = in_point.pos_1;
  assign pos[2] = in_point.pos_2;
  assign pos[3] = in_point.pos_3;
  assign pos[4] = in_point.pos_4;
  assign pos[5] = in_point.pos_5;

  jtg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_point.valid),
    .in_ready  (in_point.ready),
    .pos_i     (pos),
    .count_i   (in_point.position_count),
    .nf_i      (in_point.non_finite_mask),
    .last_i    (in_point.last_point),
    .d_valid_o (d_valid),
    .d_ready_i (d_ready),
    .delta_o   (delta),
    .info_o    (d_info)
  );

  jtg_measure u_measure (
    .clk       (clk),
    .rst_n     (rst_n),
    .d_valid_i (d_valid),
    .d_ready_o (d_ready),
    .delta_i   (delta),
    .info_i    (d_info),
    .m_valid_o (m_valid),
    .m_ready_i (m_ready),
    .mot_o     (mot),
    .info_o    (m_info)
  );

  jtg_judge u_judge (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_i       (cfg_r),
    .m_valid_i   (m_valid),
    .m_ready_o   (m_ready),
    .mot_i       (mot),
    .info_i      (m_info),
    .out_valid_o (out_verdict.valid),
    .out_ready_i (out_verdict.ready),
    .result_o    (result)
  );

  assign out_verdict.verdict    = result.verdict;
  assign out_verdict.fail_joint = result.joint;
  assign out_verdict.fail_point = result.point;

endmodule

// ----- rtl/jtg_checker.sv -----
// Port-level checks on the verdict channel of the joint trajectory guard,
// bound to the top level. Depends on jtg_pkg.
module jtg_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [2:0]                    verdict,
  input logic [jtg_pkg::JOINT_W-1:0]   fail_joint,
  input logic [jtg_pkg::POINT_W-1:0]   fail_point
);
  import jtg_pkg::*;

  // Reset empties the verdict register.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("verdict valid right after reset");

  // A stalled verdict beat keeps its contents.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(verdict) &&
                                $stable(fail_joint) && $stable(fail_point))
    else $error("stalled verdict beat changed");

  // Accept and no-joints verdicts name no joint and no point.
  a_clean_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (verdict == VERDICT_ACCEPT || verdict == VERDICT_NO_JOINTS)
      |-> fail_joint == '0 && fail_point == '0)
    else $error("accept or no-joints verdict carries a joint or point");

  // A count mismatch belongs to the point, not to a joint.
  a_count_joint: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && verdict == VERDICT_COUNT_MISMATCH |-> fail_joint == '0)
    else $error("count mismatch verdict names a joint");

  // Reversal rejections only name wrist joints.
  a_flip_joint: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && verdict == VERDICT_FLIPS
      |-> fail_joint == JOINT_W'(WRIST_FIRST) || fail_joint == JOINT_W'(WRIST_FIRST + 1) ||
          fail_joint == JOINT_W'(WRIST_FIRST + 2))
    else $error("reversal verdict names a non-wrist joint");

endmodule

bind joint_trajectory_guard_top jtg_checker u_jtg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_verdict.valid),
  .out_ready  (out_verdict.ready),
  .verdict    (out_verdict.verdict),
  .fail_joint (out_verdict.fail_joint),
  .fail_point (out_verdict.fail_point)
);

// ----- sim/testbench.sv -----
// Self-checking testbench for joint_trajectory_guard_top: directed points, then
// random trajectories under random idling.
// Depends on jtg_pkg, jtg_if and the block's RTL; verdicts are checked against a predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import jtg_pkg::*;

  localparam int RANDOM_ITEMS   = 1630;
  localparam int PHASE_ITEMS    = 150;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  typedef logic [NUM_JOINTS-1:0][POS_W-1:0] joint_vec_t;

  typedef struct packed {
    joint_vec_t         pos;
    logic [COUNT_W-1:0] count;
    logic [MASK_W-1:0]  mask;
    logic               last;
  } point_t;

  // One directed row: the point, and a hand-written verdict where one is given.
  typedef struct packed {
    point_t  pt;
    logic    typed;
    result_t want;
  } guide_row_t;

  localparam logic [POS_W-1:0] P_MAX  = 32'h7fff_ffff;
  localparam logic [POS_W-1:0] P_MIN  = 32'h8000_0000;
  localparam joint_vec_t ALL_MAX      = {NUM_JOINTS{P_MAX}};
  localparam joint_vec_t ALL_MIN      = {NUM_JOINTS{P_MIN}};
  localparam joint_vec_t ALL_ZERO     = '0;
  localparam joint_vec_t J3_UP        = {64'd0, 32'd100, 96'd0};
  localparam joint_vec_t ROLL_PLUS    = {32'd3200000, 160'd0};
  localparam joint_vec_t ROLL_MINUS   = {32'hffcf_2c00, 160'd0};
  localparam logic [LIMIT_W-1:0] LIMIT_TOP = {LIMIT_W{1'b1}};

  localparam int GUIDE_ROWS = 18;
  localparam guide_row_t GUIDE [GUIDE_ROWS] = '{
    // Single accepted point at the top of the range.
    '{'{ALL_MAX, 4'd6, 6'd0, 1'b1}, 1'b1, '{VERDICT_ACCEPT, 3'd0, 16'd0}},
    // Full-scale swing from the bottom to the top: joint 0 jumps first.
    '{'{ALL_MIN, 4'd6, 6'd0, 1'b0}, 1'b0, '{VERDICT_ACCEPT, 3'd0, 16'd0}},
    '{'{ALL_MAX, 4'd6, 6'd0, 1'b1}, 1'b1, '{VERDICT_JUMP, 3'd0, 16'd1}},
    // Position count mismatch and non-finite joints.
    '{'{ALL_ZERO, 4'd15, 6'd0, 1'b1}, 1'b1, '{VERDICT_COUNT_MISMATCH, 3'd0, 16'd0}},
    '{'{ALL_ZERO, 4'd6, 6'b100000, 1'b1}, 1'b1, '{VERDICT_NON_FINITE, 3'd5, 16'd0}},
    '{'{ALL_ZERO, 4'd6, 6'b111111, 1'b1}, 1'b1, '{VERDICT_NON_FINITE, 3'd0, 16'd0}},
    // Roll joint crossing the wrap point: a small step after folding.
    '{'{ROLL_PLUS, 4'd6, 6'd0, 1'b0}, 1'b0, '{VERDICT_ACCEPT, 3'd0, 16'd0}},
    '{'{ROLL_MINUS, 4'd6, 6'd0, 1'b1}, 1'b0, '{VERDICT_ACCEPT, 3'd0, 16'd0}},
    // Joint 3 reverses six times in a row: one more than allowed.
    '{'{ALL_ZERO, 4'd6, 6'd0, 1'b0}, 1'b0, '{VERDICT_ACCEPT, 3'd0, 16'd0}},
    '{'{J3_UP, 4'd6, 6'd0, 1'b0}, 1'b0, '{VERDICT_ACCEPT, 3'd0, 16'd0}},
    '{'{ALL_ZERO, 4'd6, 6'd0, 1'b0}, 1'b0, '{VERDICT_ACCEPT, 3'd0, 16'd0}},
    '{'{J3_UP, 4'd6, 6'd0, 1'b0}, 1'b0, '{VERDICT_ACCEPT, 3'd0, 16'd0}},
    '{'{ALL_ZERO, 4'd6, 6'd0, 1'b0}, 1'b0, '{VERDICT_ACCEPT, 3'd0, 16'd0}},
    '{'{J3_UP, 4'd6, 6'd0, 1'b0}, 1'b0, '{VERDICT_ACCEPT, 3'd0, 16'd0}},
    '{'{ALL_ZERO, 4'd6, 6'd0, 1'b0}, 1'b0, '{VERDICT_ACCEPT, 3'd0, 16'd0}},
    '{'{J3_UP, 4'd6, 6'd0, 1'b1}, 1'b1, '{VERDICT_FLIPS, 3'd3, 16'd7}},
    // A malformed point outranks a jump seen on the same point.
    '{'{ALL_ZERO, 4'd6, 6'd0, 1'b0}, 1'b0, '{VERDICT_ACCEPT, 3'd0, 16'd0}},
    '{'{ALL_MAX, 4'd0, 6'd0, 1'b1}, 1'b1, '{VERDICT_COUNT_MISMATCH, 3'd0, 16'd1}}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  jtg_point_if   point_ch ();
  jtg_verdict_if verdict_ch ();

  joint_trajectory_guard_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_point    (point_ch),
    .out_verdict (verdict_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: the register mirror and the findings of the current trajectory.
  cfg_t                   guard_cfg;
  joint_vec_t             trail_pos;
  bit                     have_prev;
  logic [POINT_W-1:0]     trail_index;
  verdict_t               bad_kind;
  logic [JOINT_W-1:0]     bad_joint;
  logic [POINT_W-1:0]     bad_point;
  bit                     jumped;
  logic [JOINT_W-1:0]     jump_joint;
  logic [POINT_W-1:0]     jump_point;
  dir_t                   wrist_dir [WRIST_COUNT];
  logic [RUN_W-1:0]       flip_run [WRIST_COUNT];
  bit                     flip_failed [WRIST_COUNT];
  logic [POINT_W-1:0]     flip_point [WRIST_COUNT];

  result_t pending_verdicts [$];
  result_t oldest;
  int      mismatches = 0;
  int      items_sent = 0;
  int      tx_gap_pct = 20;
  int      rx_stall_pct = 20;
  int      rx_hold = 0;
  int      quiet_cycles = 0;

  function automatic longint limit_of(int j);
    if (j < BASE_JOINTS) return longint'(guard_cfg.limit_base);
    if (j < ROLL_JOINT) return longint'(guard_cfg.limit_wrist);
    return longint'(guard_cfg.limit_roll);
  endfunction

  // Fold a roll step into the half-open range around zero, one turn wide.
  function automatic longint roll_fold(longint d);
    longint r;
    r = d % longint'(TWO_PI_Q20);
    if (r < 0) r = r + longint'(TWO_PI_Q20);
    if (2 * r > longint'(TWO_PI_Q20)) r = r - longint'(TWO_PI_Q20);
    return r;
  endfunction

  task automatic clear_trail();
    trail_pos   = '0;
    have_prev   = 1'b0;
    trail_index = '0;
    bad_kind    = VERDICT_ACCEPT;
    bad_joint   = '0;
    bad_point   = '0;
    jumped      = 1'b0;
    jump_joint  = '0;
    jump_point  = '0;
    for (int w = 0; w < WRIST_COUNT; w++) begin
      wrist_dir[w]   = DIR_NONE;
      flip_run[w]    = '0;
      flip_failed[w] = 1'b0;
      flip_point[w]  = '0;
    end
  endtask

  // Advance the trajectory by one accepted point; a last point yields the verdict.
  task automatic judge_point(input point_t p, output bit emits, output result_t r);
    int                 eff;
    int                 w;
    longint             d;
    longint             a;
    dir_t               dir;
    logic [POINT_W-1:0] here;
    eff   = (guard_cfg.joint_count > NUM_JOINTS) ? NUM_JOINTS : int'(guard_cfg.joint_count);
    here  = trail_index;
    emits = 1'b0;
    r     = '0;

    // Only the first malformed point is kept. The mask scan runs downward so
    // that the lowest flagged joint wins.
    if (bad_kind == VERDICT_ACCEPT) begin
      if (p.count != COUNT_W'(guard_cfg.joint_count)) begin
        bad_kind  = VERDICT_COUNT_MISMATCH;
        bad_joint = '0;
        bad_point = here;
      end else begin
        for (int j = eff - 1; j >= 0; j--) begin
          if (p.mask[j]) begin
            bad_kind  = VERDICT_NON_FINITE;
            bad_joint = JOINT_W'(j);
            bad_point = here;
          end
        end
      end
    end

    // Step checks against the previous point, and reversal runs on the wrist.
    if (have_prev) begin
      for (int j = 0; j < eff; j++) begin
        d = longint'($signed(p.pos[j])) - longint'($signed(trail_pos[j]));
        if (j == ROLL_JOINT) d = roll_fold(d);
        a = (d < 0) ? -d : d;
        if (!jumped && a > limit_of(j)) begin
          jumped     = 1'b1;
          jump_joint = JOINT_W'(j);
          jump_point = here;
        end
        if (j >= WRIST_FIRST) begin
          w = j - WRIST_FIRST;
          if (!flip_failed[w] && a >= longint'(guard_cfg.still)) begin
            dir = (d > 0) ? DIR_UP : ((d < 0) ? DIR_DOWN : DIR_NONE);
            if (wrist_dir[w] != DIR_NONE) begin
              if (dir != DIR_NONE && dir != wrist_dir[w]) begin
                if (flip_run[w] != RUN_MAX) flip_run[w] = flip_run[w] + 1'b1;
                if (flip_run[w] > guard_cfg.max_flips) begin
                  flip_failed[w] = 1'b1;
                  flip_point[w]  = here;
                end
              end else begin
                flip_run[w] = '0;
              end
            end
            wrist_dir[w] = dir;
          end
        end
      end
    end

    trail_pos = p.pos;
    have_prev = 1'b1;
    if (trail_index != POINT_MAX) trail_index = trail_index + 1'b1;

    // Verdict precedence: no joints, malformed, jump, then the lowest failed wrist joint.
    if (p.last) begin
      emits = 1'b1;
      if (guard_cfg.joint_count == '0) begin
        r.verdict = VERDICT_NO_JOINTS;
      end else if (bad_kind != VERDICT_ACCEPT) begin
        r = '{bad_kind, bad_joint, bad_point};
      end else if (jumped) begin
        r = '{VERDICT_JUMP, jump_joint, jump_point};
      end else begin
        for (int v = WRIST_COUNT - 1; v >= 0; v--) begin
          if (flip_failed[v]) r = '{VERDICT_FLIPS, JOINT_W'(WRIST_FIRST + v), flip_point[v]};
        end
      end
      clear_trail();
    end
  endtask

  function automatic int idle_len();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  task automatic idle(int n);
    repeat (n) begin
      @(negedge clk);
      point_ch.valid <= 1'b0;
    end
  endtask

  task automatic sender_gap();
    if ($urandom_range(0, 99) < tx_gap_pct) idle(idle_len());
  endtask

  // Present one point and hold it until the block takes the beat.
  task automatic drive_point(point_t p, bit typed, result_t want);
    bit      emits;
    result_t got;
    @(negedge clk);
    point_ch.valid           <= 1'b1;
    point_ch.pos_0           <= p.pos[0];
    point_ch.pos_1           <= p.pos[1];
    point_ch.pos_2           <= p.pos[2];
    point_ch.pos_3           <= p.pos[3];
    point_ch.pos_4           <= p.pos[4];
    point_ch.pos_5           <= p.pos[5];
    point_ch.position_count  <= p.count;
    point_ch.non_finite_mask <= p.mask;
    point_ch.last_point      <= p.last;
    do @(posedge clk); while (!point_ch.ready);
    judge_point(p, emits, got);
    if (emits) pending_verdicts.push_back(typed ? want : got);
    items_sent++;
  endtask

  // Stop sending and let every outstanding verdict drain out of the pipeline.
  task automatic drain_pipeline();
    idle(1);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
  endtask

  task automatic write_config(cfg_t c);
    put_reg(CFG_JOINT_COUNT, CFG_DATA_W'(c.joint_count));
    put_reg(CFG_LIMIT_BASE, CFG_DATA_W'(c.limit_base));
    put_reg(CFG_LIMIT_WRIST, CFG_DATA_W'(c.limit_wrist));
    put_reg(CFG_LIMIT_ROLL, CFG_DATA_W'(c.limit_roll));
    put_reg(CFG_STILL, CFG_DATA_W'(c.still));
    put_reg(CFG_MAX_FLIPS, CFG_DATA_W'(c.max_flips));
    @(negedge clk);
    cfg_we <= 1'b0;
    guard_cfg = c;
  endtask

  function automatic logic [LIMIT_W-1:0] pick_limit();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return LIMIT_TOP;
      2: return LIMIT_W'($urandom);
      default: return LIMIT_W'($urandom_range(1 << 16, 1 << 22));
    endcase
  endfunction

  // The first phases pin the extremes; later ones are random.
  function automatic cfg_t pick_config(int phase);
    cfg_t c;
    c.joint_count = ($urandom_range(0, 1) == 0) ? JOINT_W'(6) : JOINT_W'($urandom_range(0, 7));
    c.limit_base  = pick_limit();
    c.limit_wrist = pick_limit();
    c.limit_roll  = pick_limit();
    c.still       = ($urandom_range(0, 3) == 0) ? STILL_W'($urandom_range(0, 1023))
                                                : STILL_W'($urandom_range(0, 16));
    c.max_flips   = FLIPS_W'($urandom_range(0, 7));
    case (phase)
      0: c = CFG_RESET;
      1: c.joint_count = '0;
      2: begin
        c.joint_count = JOINT_W'(7);
        c.limit_base  = LIMIT_TOP;
        c.limit_wrist = LIMIT_TOP;
        c.limit_roll  = LIMIT_TOP;
        c.still       = '0;
        c.max_flips   = '0;
      end
      3: begin
        c.joint_count = JOINT_W'(6);
        c.limit_base  = '0;
        c.limit_wrist = '0;
        c.limit_roll  = '0;
        c.still       = {STILL_W{1'b1}};
        c.max_flips   = {FLIPS_W{1'b1}};
      end
      4: begin
        c.joint_count = JOINT_W'($urandom_range(1, 5));
        c.still       = '0;
        c.max_flips   = {FLIPS_W{1'b1}};
      end
      default: ;
    endcase
    return c;
  endfunction

  // Step for one joint of a clean trajectory: never beyond the joint's limit once
  // folded. Oscillating joints alternate sign to build reversal runs.
  function automatic longint pick_step(int j, bit osc, bit up);
    longint lim;
    longint cap;
    longint mag;
    int     r;
    lim = limit_of(j);
    cap = (lim > (longint'(1) << 22)) ? (longint'(1) << 22) : lim;
    r   = $urandom_range(0, 99);
    if (r < 40) mag = longint'($urandom_range(0, int'(guard_cfg.still) + 3));
    else if (r < 95) mag = longint'($urandom_range(0, 32'(cap)));
    else mag = lim;
    if (mag > lim) mag = lim;
    if (osc ? !up : ($urandom_range(0, 1) == 1)) mag = -mag;
    if (j == ROLL_JOINT && $urandom_range(0, 9) == 0) begin
      mag = ($urandom_range(0, 1) == 1) ? mag + longint'(TWO_PI_Q20)
                                        : mag - longint'(TWO_PI_Q20);
    end
    return mag;
  endfunction

  // One random trajectory: mostly clean walks, some with a single injected
  // fault, and some made of raw noise.
  task automatic run_trajectory();
    point_t                 p;
    joint_vec_t             walk;
    bit [NUM_JOINTS-1:0]    osc;
    bit [NUM_JOINTS-1:0]    up;
    int                     len;
    int                     kind;
    int                     bad_at;
    int                     bad_how;
    int                     eff;
    int                     pick;
    len     = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    kind    = $urandom_range(0, 99);
    bad_at  = $urandom_range(0, len - 1);
    bad_how = $urandom_range(0, 2);
    eff     = (guard_cfg.joint_count > NUM_JOINTS) ? NUM_JOINTS : int'(guard_cfg.joint_count);
    for (int j = 0; j < NUM_JOINTS; j++) begin
      walk[j] = POS_W'($urandom_range(0, 32'h3fff_ffff) - 32'h2000_0000);
      osc[j]  = ($urandom_range(0, 9) < 6);
      up[j]   = $urandom_range(0, 1);
    end
    for (int k = 0; k < len; k++) begin
      if (kind >= 85) begin
        for (int j = 0; j < NUM_JOINTS; j++) p.pos[j] = $urandom;
        p.count = COUNT_W'($urandom_range(0, 15));
        p.mask  = MASK_W'($urandom_range(0, 63));
      end else begin
        if (k > 0) begin
          for (int j = 0; j < NUM_JOINTS; j++) begin
            walk[j] = walk[j] + POS_W'(pick_step(j, osc[j], up[j]));
            up[j]   = ~up[j];
          end
        end
        p.pos   = walk;
        p.count = COUNT_W'(guard_cfg.joint_count);
        // Mask bits of joints beyond the joint count are set now and then; they must not matter.
        p.mask  = ($urandom_range(0, 2) == 0) ? MASK_W'(($urandom_range(0, 63) >> eff) << eff)
                                              : '0;
        if (kind >= 70 && k == bad_at) begin
          pick = $urandom_range(0, NUM_JOINTS - 1);
          case (bad_how)
            0: p.count = p.count + COUNT_W'($urandom_range(1, 15));
            1: p.mask[pick] = 1'b1;
            default: p.pos[pick] = $urandom;
          endcase
        end
      end
      p.last = (k == len - 1);
      sender_gap();
      drive_point(p, 1'b0, '0);
    end
  endtask

  task automatic note_fault(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%s", msg);
  endtask

  // Receiver: ready drops for random stretches, short ones mostly.
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      verdict_ch.ready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else if ($urandom_range(0, 99) < rx_stall_pct) begin
      verdict_ch.ready <= 1'b0;
      rx_hold = idle_len() - 1;
    end else begin
      verdict_ch.ready <= 1'b1;
    end
  end

  // Check every verdict beat against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && verdict_ch.valid && verdict_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        note_fault($sformatf("unexpected verdict beat: v=%0d j=%0d p=%0d",
                             verdict_ch.verdict, verdict_ch.fail_joint, verdict_ch.fail_point));
      end else begin
        oldest = pending_verdicts.pop_front();
        if (verdict_ch.verdict !== oldest.verdict || verdict_ch.fail_joint !== oldest.joint ||
            verdict_ch.fail_point !== oldest.point) begin
          note_fault($sformatf("verdict mismatch: expected v=%0d j=%0d p=%0d, got v=%0d j=%0d p=%0d",
                               oldest.verdict, oldest.joint, oldest.point, verdict_ch.verdict,
                               verdict_ch.fail_joint, verdict_ch.fail_point));
        end
      end
    end
  end

  // Watchdog: too long without a beat on either channel ends the run.
  always @(posedge clk) begin
    if (!rst_n || (point_ch.valid && point_ch.ready) || (verdict_ch.valid && verdict_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int     phase;
    int     phase_start;
    int     random_start;

    rst_n                    = 1'b0;
    cfg_we                   = 1'b0;
    cfg_index                = '0;
    cfg_wdata                = '0;
    point_ch.valid           = 1'b0;
    point_ch.pos_0           = '0;
    point_ch.pos_1           = '0;
    point_ch.pos_2           = '0;
    point_ch.pos_3           = '0;
    point_ch.pos_4           = '0;
    point_ch.pos_5           = '0;
    point_ch.position_count  = '0;
    point_ch.non_finite_mask = '0;
    point_ch.last_point      = 1'b0;
    verdict_ch.ready         = 1'b0;
    guard_cfg                = CFG_RESET;
    clear_trail();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed points at the reset configuration.
    for (int i = 0; i < GUIDE_ROWS; i++) begin
      sender_gap();
      drive_point(GUIDE[i].pt, GUIDE[i].typed, GUIDE[i].want);
    end
    drain_pipeline();

    // Random phases, each under its own configuration and idling profile.
    phase        = 0;
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      write_config(pick_config(phase));
      tx_gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      rx_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      phase_start  = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        run_trajectory();
        if ($urandom_range(0, 19) == 0) drain_pipeline();
      end
      drain_pipeline();
      phase++;
    end

    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
